// File: design/rtp_seq_sorted_insert_unit_assert.svh
// Assertion macros for the sorted sequence-number store.
// Expands to concurrent assertions in simulation and to nothing in synthesis.
`ifndef RTP_SEQ_SORTED_INSERT_UNIT_ASSERT_SVH
`define RTP_SEQ_SORTED_INSERT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RTP_SSI_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RTP_SSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`define RTP_SSI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define RTP_SSI_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define RTP_SSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define RTP_SSI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: design/rtp_ssi_pkg.sv
// Shared constants, codes and types for the sorted sequence-number store.
// No dependencies; imported by every module of the block.
`default_nettype none
package rtp_ssi_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W       = (COUNT_W > 6) ? COUNT_W : 6;

    localparam logic       ACT_INSERT = 1'b0;
    localparam logic       ACT_READ   = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_READ      = 2'd3;

    typedef struct packed {
        logic equal;
        logic newer;
        logic older;
        logic half;
    } cmp_res_t;

    function automatic logic [6:0] to_pos7(input logic [COUNT_W-1:0] v);
        logic [COUNT_W+6:0] tmp;
        tmp = {7'b0, v};
        return tmp[6:0];
    endfunction

endpackage
`default_nettype wire

// File: design/rtp_ssi_store.sv
// Entry memory: one write port and one registered read port.
// Depends on rtp_ssi_pkg for depth and index width.
`default_nettype none
module rtp_ssi_store
    import rtp_ssi_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [15:0]      wr_data,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [15:0]      rd_data
);

    logic [15:0] mem [STORE_DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: design/rtp_ssi_cmp.sv
// Shared serial-order comparator: one 16-bit wrapping subtract.
// Depends on rtp_ssi_pkg for the result struct.
`default_nettype none
module rtp_ssi_cmp
    import rtp_ssi_pkg::*;
(
    input  wire logic [15:0] value,
    input  wire logic [15:0] entry,
    output cmp_res_t         res
);

    logic [15:0] diff;

    assign diff      = value - entry;
    assign res.equal = (diff == 16'h0000);
    assign res.half  = (diff == 16'h8000);
    assign res.newer = (diff != 16'h0000) && !diff[15];
    assign res.older = diff[15] && (diff != 16'h8000);

endmodule
`default_nettype wire

// File: design/rtp_seq_sorted_insert_unit.sv
// Top level: sequencer, entry memory and comparator of the sorted store.
// Depends on rtp_ssi_pkg, rtp_ssi_store, rtp_ssi_cmp and the assertion header.
//
// Keeps up to STORE_DEPTH 16-bit RTP sequence numbers in wrap-around serial order
// and takes one word at a time; item_stall is high from acceptance until the
// result is placed in the output register, which may still hold the previous
// result while the next word is worked on. Every step goes through the single
// memory read port and the single comparator. A read, a full or first insert and
// an append need no search. Any other insert runs a binary search of at most
// ceil(log2(n+1)) probes and then moves the entries from the found place up by
// one; a probe that lands exactly half the range away ends the search at that
// place, and a duplicate ends it with no write. A stalled output holds the new
// result back in S_PUBLISH. No clearing pass is needed.
`default_nettype none
`include "rtp_seq_sorted_insert_unit_assert.svh"
module rtp_seq_sorted_insert_unit
    import rtp_ssi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        action,
    input  wire logic [15:0] seq_number,
    input  wire logic [5:0]  read_index,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       status,
    output logic [6:0]       position,
    output logic [6:0]       entry_count,
    output logic [15:0]      read_value
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_READ_WAIT  = 3'd1;
    localparam logic [2:0] S_LAST_CHK   = 3'd2;
    localparam logic [2:0] S_SEARCH_RD  = 3'd3;
    localparam logic [2:0] S_SEARCH_CMP = 3'd4;
    localparam logic [2:0] S_SHIFT_RD   = 3'd5;
    localparam logic [2:0] S_SHIFT_WR   = 3'd6;
    localparam logic [2:0] S_PUBLISH    = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] low_reg, low_next;
    logic [COUNT_W-1:0] hix_reg, hix_next;
    logic [COUNT_W-1:0] mid_reg, mid_next;
    logic [COUNT_W-1:0] pos_reg, pos_next;
    logic [COUNT_W-1:0] sh_reg, sh_next;
    logic [15:0]        value_reg, value_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [6:0]         res_pos_reg, res_pos_next;
    logic [15:0]        res_rval_reg, res_rval_next;
    logic               result_valid_reg, result_valid_next;
    logic [1:0]         status_reg, status_next;
    logic [6:0]         position_reg, position_next;
    logic [6:0]         entry_count_reg, entry_count_next;
    logic [15:0]        read_value_reg, read_value_next;

    logic               accept;
    logic               out_free;
    logic [CMP_W-1:0]   ridx_ext;
    logic [CMP_W-1:0]   count_ext;
    logic [COUNT_W:0]   mid_sum;
    logic [COUNT_W-1:0] mid_calc;
    logic [COUNT_W-1:0] count_m1;
    logic [COUNT_W-1:0] sh_m1;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [15:0]        wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [15:0]        rd_data;
    cmp_res_t           cmp;

    rtp_ssi_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rtp_ssi_cmp u_cmp (
        .value (value_reg),
        .entry (rd_data),
        .res   (cmp)
    );

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;
    assign ridx_ext   = CMP_W'(read_index);
    assign count_ext  = CMP_W'(count_reg);
    assign mid_sum    = {1'b0, low_reg} + {1'b0, hix_reg} - {{COUNT_W{1'b0}}, 1'b1};
    assign mid_calc   = mid_sum[COUNT_W:1];
    assign count_m1   = count_reg - {{(COUNT_W-1){1'b0}}, 1'b1};
    assign sh_m1      = sh_reg - {{(COUNT_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        low_next          = low_reg;
        hix_next          = hix_reg;
        mid_next          = mid_reg;
        pos_next          = pos_reg;
        sh_next           = sh_reg;
        value_next        = value_reg;
        res_status_next   = res_status_reg;
        res_pos_next      = res_pos_reg;
        res_rval_next     = res_rval_reg;
        status_next       = status_reg;
        position_next     = position_reg;
        entry_count_next  = entry_count_reg;
        read_value_next   = read_value_reg;
        result_valid_next = result_valid_reg && result_stall;
        wr_en             = 1'b0;
        wr_addr           = '0;
        wr_data           = value_reg;
        rd_addr           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next    = seq_number;
                    res_rval_next = 16'h0000;
                    res_pos_next  = 7'd0;
                    if (action == ACT_READ)
                    begin
                        res_status_next = ST_READ;
                        res_pos_next    = {1'b0, read_index};
                        rd_addr         = ridx_ext[IDX_W-1:0];
                        if (ridx_ext < count_ext)
                        begin
                            state_next = S_READ_WAIT;
                        end
                        else
                        begin
                            state_next = S_PUBLISH;
                        end
                    end
                    else if (count_reg >= COUNT_W'(STORE_DEPTH))
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_PUBLISH;
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en           = 1'b1;
                        wr_addr         = '0;
                        wr_data         = seq_number;
                        count_next      = {{(COUNT_W-1){1'b0}}, 1'b1};
                        res_status_next = ST_INSERTED;
                        state_next      = S_PUBLISH;
                    end
                    else
                    begin
                        rd_addr    = count_m1[IDX_W-1:0];
                        state_next = S_LAST_CHK;
                    end
                end
            end
            S_READ_WAIT:
            begin
                res_rval_next = rd_data;
                state_next    = S_PUBLISH;
            end
            S_LAST_CHK:
            begin
                if (cmp.newer)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = count_reg[IDX_W-1:0];
                    count_next      = count_reg + {{(COUNT_W-1){1'b0}}, 1'b1};
                    res_status_next = ST_INSERTED;
                    res_pos_next    = to_pos7(count_reg);
                    state_next      = S_PUBLISH;
                end
                else
                begin
                    low_next   = '0;
                    hix_next   = count_reg;
                    state_next = S_SEARCH_RD;
                end
            end
            S_SEARCH_RD:
            begin
                if (low_reg < hix_reg)
                begin
                    rd_addr    = mid_calc[IDX_W-1:0];
                    mid_next   = mid_calc;
                    state_next = S_SEARCH_CMP;
                end
                else
                begin
                    pos_next   = low_reg;
                    sh_next    = count_reg;
                    state_next = S_SHIFT_RD;
                end
            end
            S_SEARCH_CMP:
            begin
                priority if (cmp.equal)
                begin
                    res_status_next = ST_DUPLICATE;
                    res_pos_next    = to_pos7(mid_reg);
                    state_next      = S_PUBLISH;
                end
                else if (cmp.older)
                begin
                    hix_next   = mid_reg;
                    state_next = S_SEARCH_RD;
                end
                else if (cmp.newer)
                begin
                    low_next   = mid_reg + {{(COUNT_W-1){1'b0}}, 1'b1};
                    state_next = S_SEARCH_RD;
                end
                else
                begin
                    pos_next   = mid_reg;
                    sh_next    = count_reg;
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (sh_reg > pos_reg)
                begin
                    rd_addr    = sh_m1[IDX_W-1:0];
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    wr_en           = 1'b1;
                    wr_addr         = pos_reg[IDX_W-1:0];
                    count_next      = count_reg + {{(COUNT_W-1){1'b0}}, 1'b1};
                    res_status_next = ST_INSERTED;
                    res_pos_next    = to_pos7(pos_reg);
                    state_next      = S_PUBLISH;
                end
            end
            S_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = sh_reg[IDX_W-1:0];
                wr_data    = rd_data;
                sh_next    = sh_m1;
                state_next = S_SHIFT_RD;
            end
            S_PUBLISH:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    status_next       = res_status_reg;
                    position_next     = res_pos_reg;
                    entry_count_next  = to_pos7(count_reg);
                    read_value_next   = res_rval_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg         <= low_next;
        hix_reg         <= hix_next;
        mid_reg         <= mid_next;
        pos_reg         <= pos_next;
        sh_reg          <= sh_next;
        value_reg       <= value_next;
        res_status_reg  <= res_status_next;
        res_pos_reg     <= res_pos_next;
        res_rval_reg    <= res_rval_next;
        status_reg      <= status_next;
        position_reg    <= position_next;
        entry_count_reg <= entry_count_next;
        read_value_reg  <= read_value_next;
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign position     = position_reg;
    assign entry_count  = entry_count_reg;
    assign read_value   = read_value_reg;

    `RTP_SSI_ASSERT_HOLDS(a_count_bound, clk, rst_n, count_reg <= COUNT_W'(STORE_DEPTH), "entry count beyond store depth")
    `RTP_SSI_ASSERT_SAME(a_publish_only, clk, rst_n, $rose(result_valid), $past(state_reg) == S_PUBLISH, "result raised outside publish")
    `RTP_SSI_ASSERT_NEXT(a_full_hold, clk, rst_n, accept && action == ACT_INSERT && count_reg == COUNT_W'(STORE_DEPTH), $stable(count_reg), "full store changed on insert")
    `RTP_SSI_ASSERT_SAME(a_shift_range, clk, rst_n, state_reg == S_SHIFT_WR, sh_reg > pos_reg && sh_reg < COUNT_W'(STORE_DEPTH), "shift pointer out of range")

endmodule
`default_nettype wire
